// ----- rtl/vau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vau_pkg
// Shared widths, law codes, register indexes, stage bundle and the
// reciprocal table of the value approach unit.
// ----------------------------------------------------------------------------
package vau_pkg;

   // field widths
   localparam int unsigned DataWidth    = 16;
   localparam int unsigned DiffWidth    = DataWidth + 1;
   localparam int unsigned LimWidth     = 15;
   localparam int unsigned ModeWidth    = 4;
   localparam int unsigned TimeWidth    = 4;
   localparam int unsigned RecipWidth   = 12;
   localparam int unsigned FracBits     = 12;
   localparam int unsigned ProdWidth    = DiffWidth + RecipWidth + 1;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = LimWidth;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_LAW_MODE   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_STEP_LIMIT = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_TIME_INDEX = 2'd2;

   // approach law codes
   localparam logic [ModeWidth-1:0] MODE_EXP2  = 4'd0;
   localparam logic [ModeWidth-1:0] MODE_EXP4  = 4'd1;
   localparam logic [ModeWidth-1:0] MODE_EXP8  = 4'd2;
   localparam logic [ModeWidth-1:0] MODE_TIME  = 4'd3;
   localparam logic [ModeWidth-1:0] MODE_CLAMP = 4'd4;
   localparam logic [ModeWidth-1:0] MODE_SLEW  = 4'd5;
   localparam logic [ModeWidth-1:0] MODE_DEAD2 = 4'd6;
   localparam logic [ModeWidth-1:0] MODE_DEAD4 = 4'd7;
   localparam logic [ModeWidth-1:0] MODE_DEAD8 = 4'd8;

   typedef logic [RecipWidth-1:0] recip_type;

   // item bundle after the first stage
   typedef struct packed {
      logic [DataWidth-1:0]        cur;
      logic [DataWidth-1:0]        tgt;
      logic signed [DiffWidth-1:0] diff;
      logic [ModeWidth-1:0]        mode;
      logic [LimWidth-1:0]         lim;
      recip_type                   recip;
      logic                        last;
   } stage_type;

   // floor(4096 / (n + 1)), entry zero means jump to the target
   function automatic recip_type recip_lookup(input logic [TimeWidth-1:0] idx);
      recip_type r;
      case (idx)
         4'd0:    r = 12'h000;
         4'd1:    r = 12'h800;
         4'd2:    r = 12'h555;
         4'd3:    r = 12'h400;
         4'd4:    r = 12'h333;
         4'd5:    r = 12'h2AA;
         4'd6:    r = 12'h249;
         4'd7:    r = 12'h200;
         4'd8:    r = 12'h1C7;
         4'd9:    r = 12'h199;
         4'd10:   r = 12'h174;
         4'd11:   r = 12'h155;
         4'd12:   r = 12'h13B;
         4'd13:   r = 12'h124;
         4'd14:   r = 12'h111;
         4'd15:   r = 12'h100;
         default: r = 12'h000;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/vau_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vau_datapath
// Second and third stages: divided steps, reciprocal multiply and limit
// compares, then law selection and the final wrapped add into the result
// register.
// ----------------------------------------------------------------------------
module vau_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                s1_valid,
   input  vau_pkg::stage_type                  s1,
   output logic                                rsp_valid,
   output logic signed [vau_pkg::DataWidth-1:0] rsp_next_value,
   output logic                                rsp_last_out
);

   localparam int unsigned DW = vau_pkg::DataWidth;
   localparam int unsigned FW = vau_pkg::DiffWidth;
   localparam int unsigned PW = vau_pkg::ProdWidth;
   localparam int unsigned LW = vau_pkg::LimWidth;
   localparam int unsigned HW = PW - vau_pkg::FracBits;

   localparam logic signed [FW-1:0] Two      = 17'sd2;
   localparam logic signed [FW-1:0] Four     = 17'sd4;
   localparam logic signed [FW-1:0] Eight    = 17'sd8;
   localparam logic signed [FW-1:0] NegTwo   = -17'sd2;
   localparam logic signed [FW-1:0] NegFour  = -17'sd4;
   localparam logic signed [FW-1:0] NegEight = -17'sd8;
   localparam logic signed [FW-1:0] Zero     = 17'sd0;

   // stage 2 registers
   logic                           v2_ff, v2_in;
   logic [DW-1:0]                  cur2_ff, cur2_in;
   logic [DW-1:0]                  tgt2_ff, tgt2_in;
   logic [vau_pkg::ModeWidth-1:0]  mode2_ff, mode2_in;
   logic [LW-1:0]                  lim2_ff, lim2_in;
   logic                           last2_ff, last2_in;
   logic signed [FW-1:0]           q2_ff, q2_in;
   logic signed [FW-1:0]           q4_ff, q4_in;
   logic signed [FW-1:0]           q8_ff, q8_in;
   logic                           small2_ff, small2_in;
   logic                           small4_ff, small4_in;
   logic                           small8_ff, small8_in;
   logic signed [PW-1:0]           prod_ff, prod_in;
   logic                           rzero_ff, rzero_in;
   logic                           gt_ff, gt_in;
   logic                           lt_ff, lt_in;
   logic                           pos_ff, pos_in;

   // result registers
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                  rsp_value_ff, rsp_value_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic signed [FW-1:0]           d;
   logic signed [FW-1:0]           lim_s1;
   logic signed [FW-1:0]           lim_s2;
   logic signed [FW-1:0]           qsel;
   logic                           qsmall;
   logic                           big_step;
   logic [HW-1:0]                  prod_hi;
   logic                           prod_corr;
   logic [DW-1:0]                  lim16;

   // stage 2: truncating quotients, multiply and limit compares
   always_comb begin
      d        = s1.diff;
      lim_s1   = $signed({2'b00, s1.lim});
      v2_in    = s1_valid;
      cur2_in  = s1.cur;
      tgt2_in  = s1.tgt;
      mode2_in = s1.mode;
      lim2_in  = s1.lim;
      last2_in = s1.last;
      // floor shift plus one where a negative value had bits shifted out
      q2_in    = (d >>> 1) + $signed({16'b0, d[FW-1] & d[0]});
      q4_in    = (d >>> 2) + $signed({16'b0, d[FW-1] & (|d[1:0])});
      q8_in    = (d >>> 3) + $signed({16'b0, d[FW-1] & (|d[2:0])});
      small2_in = (d < Two) && (d > NegTwo);
      small4_in = (d < Four) && (d > NegFour);
      small8_in = (d < Eight) && (d > NegEight);
      prod_in  = d * $signed({1'b0, s1.recip});
      rzero_in = (s1.recip == '0);
      gt_in    = d > lim_s1;
      lt_in    = d < -lim_s1;
      pos_in   = d > Zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      cur2_ff   <= cur2_in;
      tgt2_ff   <= tgt2_in;
      mode2_ff  <= mode2_in;
      lim2_ff   <= lim2_in;
      last2_ff  <= last2_in;
      q2_ff     <= q2_in;
      q4_ff     <= q4_in;
      q8_ff     <= q8_in;
      small2_ff <= small2_in;
      small4_ff <= small4_in;
      small8_ff <= small8_in;
      prod_ff   <= prod_in;
      rzero_ff  <= rzero_in;
      gt_ff     <= gt_in;
      lt_ff     <= lt_in;
      pos_ff    <= pos_in;
   end

   // stage 3: pick the law and form the wrapped result
   always_comb begin
      lim_s2    = $signed({2'b00, lim2_ff});
      lim16     = {1'b0, lim2_ff};
      prod_hi   = prod_ff[PW-1:vau_pkg::FracBits];
      prod_corr = prod_ff[PW-1] & (|prod_ff[vau_pkg::FracBits-1:0]);
      case (mode2_ff)
         vau_pkg::MODE_EXP2, vau_pkg::MODE_DEAD2: begin
            qsel   = q2_ff;
            qsmall = small2_ff;
         end
         vau_pkg::MODE_EXP4, vau_pkg::MODE_DEAD4: begin
            qsel   = q4_ff;
            qsmall = small4_ff;
         end
         default: begin
            qsel   = q8_ff;
            qsmall = small8_ff;
         end
      endcase
      big_step = (qsel >= lim_s2) || (qsel <= -lim_s2);

      case (mode2_ff)
         vau_pkg::MODE_EXP2, vau_pkg::MODE_EXP4, vau_pkg::MODE_EXP8: begin
            rsp_value_in = qsmall ? tgt2_ff : cur2_ff + qsel[DW-1:0];
         end
         vau_pkg::MODE_TIME: begin
            rsp_value_in = rzero_ff ? tgt2_ff
                         : cur2_ff + prod_hi[DW-1:0] + {{(DW-1){1'b0}}, prod_corr};
         end
         vau_pkg::MODE_CLAMP: begin
            if (gt_ff) begin
               rsp_value_in = tgt2_ff - lim16;
            end else if (lt_ff) begin
               rsp_value_in = tgt2_ff + lim16;
            end else begin
               rsp_value_in = cur2_ff;
            end
         end
         vau_pkg::MODE_SLEW: begin
            if (pos_ff) begin
               rsp_value_in = gt_ff ? cur2_ff + lim16 : tgt2_ff;
            end else begin
               rsp_value_in = lt_ff ? cur2_ff - lim16 : tgt2_ff;
            end
         end
         vau_pkg::MODE_DEAD2, vau_pkg::MODE_DEAD4, vau_pkg::MODE_DEAD8: begin
            rsp_value_in = big_step ? cur2_ff + qsel[DW-1:0] : tgt2_ff;
         end
         default: begin
            rsp_value_in = cur2_ff;
         end
      endcase
      rsp_valid_in = v2_ff;
      rsp_last_in  = last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_value = $signed(rsp_value_ff);
   assign rsp_last_out   = rsp_last_ff;

   // zero reciprocal jumps straight to the target
   a_time_zero_recip: assert property (@(posedge clock) disable iff (reset)
      v2_ff && (mode2_ff == vau_pkg::MODE_TIME) && rzero_ff
      |=> rsp_value_ff == $past(tgt2_ff))
      else $error("time law with zero reciprocal did not give the target");

   // unused law codes pass the current value through
   a_unused_mode: assert property (@(posedge clock) disable iff (reset)
      v2_ff && (mode2_ff > vau_pkg::MODE_DEAD8)
      |=> rsp_value_ff == $past(cur2_ff))
      else $error("unused law code changed the value");

endmodule

// ----- rtl/value_approach_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_approach_unit
// Moves one signed 16-bit element toward its target by a configured law.
// ----------------------------------------------------------------------------
// One item can be taken in every clock cycle in which start is high and
// busy is low, and each result appears on rsp_* in order, marked by a
// one-cycle rsp_valid strobe; the receiver cannot hold results off, so it
// must take every strobe. busy is high only while reset is held. The three
// stages are input capture with the difference, the 17x13 reciprocal
// multiply with the divided steps and limit compares, and the law select
// with the final wrapped add. Write the csr_* registers only while no item
// is in flight.
// ----------------------------------------------------------------------------
module value_approach_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [vau_pkg::DataWidth-1:0]  req_current,
   input  logic signed [vau_pkg::DataWidth-1:0]  req_target,
   input  logic                                  req_last,
   input  logic                                  csr_we,
   input  logic [vau_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [vau_pkg::CsrDataWidth-1:0]      csr_wdata,
   output logic                                  rsp_valid,
   output logic signed [vau_pkg::DataWidth-1:0]  rsp_next_value,
   output logic                                  rsp_last_out
);

   localparam int unsigned DW = vau_pkg::DataWidth;

   // configuration registers
   logic [vau_pkg::ModeWidth-1:0] law_mode_ff, law_mode_in;
   logic [vau_pkg::LimWidth-1:0]  step_limit_ff, step_limit_in;
   logic [vau_pkg::TimeWidth-1:0] time_index_ff, time_index_in;

   // first stage
   logic                s1_valid_ff, s1_valid_in;
   vau_pkg::stage_type  s1_ff, s1_in;
   logic                accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   // register writes, indexes beyond the list are dropped
   always_comb begin
      law_mode_in   = law_mode_ff;
      step_limit_in = step_limit_ff;
      time_index_in = time_index_ff;
      if (csr_we) begin
         case (csr_index)
            vau_pkg::CSR_LAW_MODE:   law_mode_in   = csr_wdata[vau_pkg::ModeWidth-1:0];
            vau_pkg::CSR_STEP_LIMIT: step_limit_in = csr_wdata[vau_pkg::LimWidth-1:0];
            vau_pkg::CSR_TIME_INDEX: time_index_in = csr_wdata[vau_pkg::TimeWidth-1:0];
            default: ;
         endcase
      end
   end

   // item capture and difference
   always_comb begin
      s1_valid_in  = accept;
      s1_in.cur    = req_current;
      s1_in.tgt    = req_target;
      s1_in.diff   = $signed({req_target[DW-1], req_target})
                   - $signed({req_current[DW-1], req_current});
      s1_in.mode   = law_mode_ff;
      s1_in.lim    = step_limit_ff;
      s1_in.recip  = vau_pkg::recip_lookup(time_index_ff);
      s1_in.last   = req_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         law_mode_ff   <= '0;
         step_limit_ff <= '0;
         time_index_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         law_mode_ff   <= law_mode_in;
         step_limit_ff <= step_limit_in;
         time_index_ff <= time_index_in;
         s1_valid_ff   <= s1_valid_in;
      end
      s1_ff <= s1_in;
   end

   vau_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid_ff),
      .s1             (s1_ff),
      .rsp_valid      (rsp_valid),
      .rsp_next_value (rsp_next_value),
      .rsp_last_out   (rsp_last_out)
   );

   // every item taken gives one result strobe
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("item taken without a result three cycles later");

   // no result strobe without a matching item taken earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##3 !rsp_valid)
      else $error("result strobe without a matching item");

endmodule
